### rtl/sve_pkg.sv
// shared types, constants and helpers of the velocity gradient stencil
`default_nettype none

package sve_pkg;

    localparam int FRAC_BITS_DEF = 32;
    localparam int CFG_IDX_W     = 8;
    // widest signed numerator: sums of four 64-bit terms
    localparam int NUM_W         = 67;
    localparam int MUL_A_W       = 65;
    localparam int MUL_B_W       = 64;

    localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_LAT    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DLAT_EDGE  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DLAT_BELOW = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DLAT_ABOVE = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TAN_CENTER = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TAN_EB     = 8'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TAN_EA     = 8'd7;

    // one entry per arithmetic step of a column
    typedef enum logic [3:0] {
        ST_RC,
        ST_DU1,
        ST_DU2,
        ST_DV1,
        ST_DV2,
        ST_UD1,
        ST_UD2,
        ST_UTM,
        ST_UTD,
        ST_VD1,
        ST_VD2,
        ST_VTM1,
        ST_VTM2,
        ST_VTD
    } t_step;

    typedef struct packed {
        logic  accept;
        logic  start;
        logic  load_out;
        t_step step;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic done;
    } t_stat;

    function automatic logic signed [NUM_W-1:0] sext64(input logic signed [63:0] x);
        return {{(NUM_W-64){x[63]}}, x};
    endfunction

endpackage

`default_nettype wire

### rtl/sve_if.sv
// stream channels for column words and result words
`default_nettype none

interface sve_in_if;
    logic               valid;
    logic               ready;
    logic               row_start;
    logic signed [63:0] u_below;
    logic signed [63:0] u_center;
    logic signed [63:0] u_above;
    logic signed [63:0] v_below;
    logic signed [63:0] v_center;
    logic [62:0]        lon_step;

    modport source(output valid, row_start, u_below, u_center, u_above, v_below,
                   v_center, lon_step, input ready);
    modport sink(input valid, row_start, u_below, u_center, u_above, v_below,
                 v_center, lon_step, output ready);
endinterface

interface sve_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] du_dlon;
    logic signed [63:0] du_dlat_term;
    logic signed [63:0] dv_dlon;
    logic signed [63:0] dv_dlat_term;

    modport source(output valid, du_dlon, du_dlat_term, dv_dlon, dv_dlat_term,
                   input ready);
    modport sink(input valid, du_dlon, du_dlat_term, dv_dlon, dv_dlat_term,
                 output ready);
endinterface

`default_nettype wire

### rtl/sve_div.sv
// bit-serial restoring divider: (|n| << frac) / d, signed and saturated to 64 bits
`default_nettype none

module sve_div
    import sve_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int DVW       = 66
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [DVW-1:0]          i_den,
    output logic                    o_done,
    output logic signed [63:0]      o_quot
);

    localparam int MW = NUM_W + FRAC_BITS;
    localparam int CW = $clog2(MW + 1);

    logic [CW-1:0]  r_cnt;
    logic           r_fin;
    logic           r_neg;
    logic [MW-1:0]  r_n;
    logic [MW-1:0]  r_q;
    logic [DVW-1:0] r_rem;
    logic [DVW-1:0] r_d;

    logic [NUM_W-1:0] mag;
    logic [DVW:0]     rem_sh;
    logic [DVW:0]     rem_sub;
    logic             qbit;
    logic [63:0]      sat_q;

    assign mag     = i_num[NUM_W-1] ? (~i_num + 1'b1) : i_num;
    assign rem_sh  = {r_rem, r_n[MW-1]};
    assign qbit    = (rem_sh >= {1'b0, r_d});
    assign rem_sub = rem_sh - {1'b0, r_d};

    always_comb begin
        if (!r_neg) begin
            sat_q = (|r_q[MW-1:63]) ? MAX64 : {1'b0, r_q[62:0]};
        end else if ((|r_q[MW-1:64]) || (r_q[63] && (|r_q[62:0]))) begin
            sat_q = MIN64;
        end else begin
            sat_q = ~r_q[63:0] + 64'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_fin  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_neg <= i_num[NUM_W-1];
                r_d   <= i_den;
                r_rem <= '0;
                r_q   <= '0;
                r_n   <= {mag, {FRAC_BITS{1'b0}}};
                if (i_den == '0) begin
                    // zero divisor: zero numerator gives zero, else saturate by its sign
                    o_done <= 1'b1;
                    if (i_num == '0) begin
                        o_quot <= '0;
                    end else if (i_num[NUM_W-1]) begin
                        o_quot <= MIN64;
                    end else begin
                        o_quot <= MAX64;
                    end
                end else begin
                    r_cnt <= CW'(MW);
                end
            end else if (r_cnt != '0) begin
                r_rem <= qbit ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];
                r_q   <= {r_q[MW-2:0], qbit};
                r_n   <= {r_n[MW-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_fin <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                o_done <= 1'b1;
                o_quot <= sat_q;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/sve_mul.sv
// bit-serial shift-add multiplier for unsigned magnitudes
`default_nettype none

module sve_mul
    import sve_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [MUL_A_W-1:0]           i_a,
    input  logic [MUL_B_W-1:0]           i_b,
    output logic                         o_done,
    output logic [MUL_A_W+MUL_B_W-1:0]   o_prod
);

    localparam int PW = MUL_A_W + MUL_B_W;
    localparam int CW = $clog2(MUL_B_W + 1);

    logic [CW-1:0]      r_cnt;
    logic [PW-1:0]      r_a;
    logic [MUL_B_W-1:0] r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_a    <= {{MUL_B_W{1'b0}}, i_a};
                r_b    <= i_b;
                o_prod <= '0;
                r_cnt  <= CW'(MUL_B_W);
            end else if (r_cnt != '0) begin
                if (r_b[0]) begin
                    o_prod <= o_prod + r_a;
                end
                r_a   <= {r_a[PW-2:0], 1'b0};
                r_b   <= {1'b0, r_b[MUL_B_W-1:1]};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

### rtl/sve_dp.sv
// datapath: row geometry, column history, operand selection and result registers
`default_nettype none

module sve_dp
    import sve_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_row_start,
    input  logic signed [63:0]   i_u_below,
    input  logic signed [63:0]   i_u_center,
    input  logic signed [63:0]   i_u_above,
    input  logic signed [63:0]   i_v_below,
    input  logic signed [63:0]   i_v_center,
    input  logic [62:0]          i_lon_step,
    output logic signed [63:0]   o_du_dlon,
    output logic signed [63:0]   o_du_dlat_term,
    output logic signed [63:0]   o_dv_dlon,
    output logic signed [63:0]   o_dv_dlat_term
);

    localparam int RCW = 96 - FRAC_BITS;
    localparam int DVW = ((RCW > 65) ? RCW : 65) + 1;
    localparam int PRW = MUL_A_W + MUL_B_W;
    localparam int PMW = PRW - FRAC_BITS;
    localparam int PSW = PMW + 1;
    localparam int HSW = PSW + 1;

    // geometry registers
    logic [62:0]        r_radius;
    logic [32:0]        r_cos;
    logic [62:0]        r_dle;
    logic [62:0]        r_dlb;
    logic [62:0]        r_dla;
    logic signed [63:0] r_tc;
    logic signed [63:0] r_teb;
    logic signed [63:0] r_tea;

    // two kept columns: a older, b newer
    logic signed [63:0] r_ua_b, r_ua_c, r_ua_a, r_ub_b, r_ub_c, r_ub_a;
    logic signed [63:0] r_va_b, r_va_c, r_vb_b, r_vb_c;
    logic [62:0]        r_lon;
    logic [1:0]         r_cols;

    // operands frozen for the column under work
    logic signed [NUM_W-1:0] r_w_du, r_w_dv, r_w_us, r_w_uc, r_w_vd;
    logic signed [63:0]      r_w_vbb, r_w_vbc;
    logic [62:0]             r_w_l;

    logic [RCW-1:0]     r_rc;
    logic signed [63:0] r_t, r_dud, r_dvd;
    logic signed [PSW-1:0] r_p1, r_p2;
    logic signed [63:0] r_res0, r_res1, r_res2, r_res3;

    logic                    emit;
    logic                    is_mul;
    logic [MUL_A_W-1:0]      mul_a;
    logic [MUL_B_W-1:0]      mul_b;
    logic                    mul_neg;
    logic                    mul_done;
    logic [PRW-1:0]          mul_prod;
    logic signed [NUM_W-1:0] div_num;
    logic [DVW-1:0]          div_den;
    logic                    div_done;
    logic signed [63:0]      div_q;

    logic [PSW-1:0]     p_pos;
    logic [PSW-1:0]     p_s;
    logic [HSW-1:0]     h_sum;
    logic [HSW-1:0]     h_mag;
    logic [HSW-1:0]     h_shr;
    logic [HSW-1:0]     h_half;
    logic signed [63:0] tan_num;
    logic [63:0]        dlat_sum;

    function automatic logic [MUL_A_W-1:0] mag_a(input logic signed [NUM_W-1:0] x);
        logic [NUM_W-1:0] m;
        m = x[NUM_W-1] ? (~x + 1'b1) : x;
        return m[MUL_A_W-1:0];
    endfunction

    function automatic logic [63:0] mag_b(input logic signed [63:0] x);
        return x[63] ? (~x + 64'd1) : x;
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] == s[63]) begin
            return s[63:0];
        end
        return s[64] ? MIN64 : MAX64;
    endfunction

    assign emit        = !i_row_start && r_cols[1];
    assign o_stat.emit = emit;
    assign o_stat.done = mul_done | div_done;

    assign is_mul = (i_cmd.step == ST_RC) || (i_cmd.step == ST_UTM) ||
                    (i_cmd.step == ST_VTM1) || (i_cmd.step == ST_VTM2);

    // product back to signed Q form
    assign p_pos = {1'b0, mul_prod[PRW-1:FRAC_BITS]};
    assign p_s   = mul_neg ? (~p_pos + 1'b1) : p_pos;

    // halve toward zero and saturate the tangent term
    assign h_sum  = {r_p1[PSW-1], r_p1} + {r_p2[PSW-1], r_p2};
    assign h_mag  = h_sum[HSW-1] ? (~h_sum + 1'b1) : h_sum;
    assign h_shr  = {1'b0, h_mag[HSW-1:1]};
    assign h_half = h_sum[HSW-1] ? (~h_shr + 1'b1) : h_shr;

    always_comb begin
        if ((&h_half[HSW-1:63]) || !(|h_half[HSW-1:63])) begin
            tan_num = h_half[63:0];
        end else begin
            tan_num = h_half[HSW-1] ? MIN64 : MAX64;
        end
    end

    assign dlat_sum = {1'b0, r_dlb} + {1'b0, r_dla};

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        div_num = '0;
        div_den = '0;
        unique case (i_cmd.step)
            ST_RC: begin
                mul_a = {2'b00, r_radius};
                mul_b = {31'd0, r_cos};
            end
            ST_UTM: begin
                mul_a   = mag_a(r_w_uc);
                mul_b   = mag_b(r_tc);
                mul_neg = r_w_uc[NUM_W-1] ^ r_tc[63];
            end
            ST_VTM1: begin
                mul_a   = mag_a(sext64(r_w_vbb));
                mul_b   = mag_b(r_teb);
                mul_neg = r_w_vbb[63] ^ r_teb[63];
            end
            ST_VTM2: begin
                mul_a   = mag_a(sext64(r_w_vbc));
                mul_b   = mag_b(r_tea);
                mul_neg = r_w_vbc[63] ^ r_tea[63];
            end
            ST_DU1: begin
                div_num = r_w_du;
                div_den = {{(DVW-63){1'b0}}, r_w_l};
            end
            ST_DV1: begin
                div_num = r_w_dv;
                div_den = {{(DVW-65){1'b0}}, r_w_l, 2'b00};
            end
            ST_DU2, ST_DV2: begin
                div_num = sext64(r_t);
                div_den = {{(DVW-RCW){1'b0}}, r_rc};
            end
            ST_UD1: begin
                div_num = r_w_us;
                div_den = {{(DVW-65){1'b0}}, dlat_sum, 1'b0};
            end
            ST_VD1: begin
                div_num = r_w_vd;
                div_den = {{(DVW-63){1'b0}}, r_dle};
            end
            ST_UD2, ST_VD2: begin
                div_num = sext64(r_t);
                div_den = {{(DVW-63){1'b0}}, r_radius};
            end
            ST_UTD, ST_VTD: begin
                div_num = sext64(tan_num);
                div_den = {{(DVW-63){1'b0}}, r_radius};
            end
            default: begin
            end
        endcase
    end

    sve_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start && is_mul),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    sve_div #(
        .FRAC_BITS (FRAC_BITS),
        .DVW       (DVW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start && !is_mul),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
            r_cos    <= 33'(64'd1 << FRAC_BITS);
            r_dle    <= '0;
            r_dlb    <= '0;
            r_dla    <= '0;
            r_tc     <= '0;
            r_teb    <= '0;
            r_tea    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RADIUS:     r_radius <= i_cfg_data[62:0];
                CFG_COS_LAT:    r_cos    <= i_cfg_data[32:0];
                CFG_DLAT_EDGE:  r_dle    <= i_cfg_data[62:0];
                CFG_DLAT_BELOW: r_dlb    <= i_cfg_data[62:0];
                CFG_DLAT_ABOVE: r_dla    <= i_cfg_data[62:0];
                CFG_TAN_CENTER: r_tc     <= i_cfg_data;
                CFG_TAN_EB:     r_teb    <= i_cfg_data;
                CFG_TAN_EA:     r_tea    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= '0;
        end else if (i_cmd.accept) begin
            r_cols <= i_row_start ? 2'd1 : (r_cols[1] ? 2'd2 : r_cols + 2'd1);
        end
    end

    // column history and frozen operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            if (emit) begin
                r_w_du  <= sext64(r_ub_c) - sext64(r_ua_c);
                r_w_dv  <= (sext64(i_v_below) + sext64(i_v_center))
                         - (sext64(r_va_b) + sext64(r_va_c));
                r_w_us  <= (sext64(r_ua_a) + sext64(r_ub_a))
                         - (sext64(r_ua_b) + sext64(r_ub_b));
                r_w_uc  <= sext64(r_ua_c) + sext64(r_ub_c);
                r_w_vd  <= sext64(r_vb_c) - sext64(r_vb_b);
                r_w_vbb <= r_vb_b;
                r_w_vbc <= r_vb_c;
                r_w_l   <= r_lon;
            end
            r_ua_b <= r_ub_b;
            r_ua_c <= r_ub_c;
            r_ua_a <= r_ub_a;
            r_ub_b <= i_u_below;
            r_ub_c <= i_u_center;
            r_ub_a <= i_u_above;
            r_va_b <= r_vb_b;
            r_va_c <= r_vb_c;
            r_vb_b <= i_v_below;
            r_vb_c <= i_v_center;
            r_lon  <= i_lon_step;
        end
    end

    // step results
    always_ff @(posedge i_clk) begin
        if (o_stat.done) begin
            unique case (i_cmd.step)
                ST_RC:                          r_rc <= mul_prod[FRAC_BITS +: RCW];
                ST_DU1, ST_DV1, ST_UD1, ST_VD1: r_t  <= div_q;
                ST_DU2:                         r_res0 <= div_q;
                ST_DV2:                         r_res2 <= div_q;
                ST_UD2:                         r_dud  <= div_q;
                ST_VD2:                         r_dvd  <= div_q;
                ST_UTM: begin
                    r_p1 <= p_s;
                    r_p2 <= '0;
                end
                ST_VTM1:                        r_p1 <= p_s;
                ST_VTM2:                        r_p2 <= p_s;
                ST_UTD:                         r_res1 <= sat_add(r_dud, div_q);
                ST_VTD:                         r_res3 <= sat_add(r_dvd, div_q);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_du_dlon      <= r_res0;
            o_du_dlat_term <= r_res1;
            o_dv_dlon      <= r_res2;
            o_dv_dlat_term <= r_res3;
        end
    end

endmodule

`default_nettype wire

### rtl/sve_ctrl.sv
// controller: accepts columns, sequences the arithmetic steps, drives the result word's valid
`default_nettype none

module sve_ctrl
    import sve_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT,
        S_DONE
    } t_state;

    t_state r_state;
    t_step  r_step;
    logic   load;

    assign o_in_ready     = (r_state == S_IDLE);
    assign load           = (r_state == S_DONE) && (!o_out_valid || i_out_ready);
    assign o_cmd.accept   = i_in_valid && o_in_ready;
    assign o_cmd.start    = (r_state == S_RUN);
    assign o_cmd.load_out = load;
    assign o_cmd.step     = r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_RC;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && i_stat.emit) begin
                        r_step  <= ST_RC;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (i_stat.done) begin
                        if (r_step == ST_VTD) begin
                            r_state <= S_DONE;
                        end else begin
                            r_step  <= t_step'(r_step + 4'd1);
                            r_state <= S_RUN;
                        end
                    end
                end
                S_DONE: begin
                    // wait for the output register to free up
                    if (load) begin
                        o_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_start_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |-> !i_stat.done)
        else $error("step finished in the cycle of its start");
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.done |-> (r_state == S_WAIT))
        else $error("step finished outside of wait state");
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> o_out_valid)
        else $error("result word loaded without valid");
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |-> !o_cmd.start && !o_cmd.load_out)
        else $error("column accepted while busy");
`endif

endmodule

`default_nettype wire

### rtl/sphere_velocity_gradient_stencil.sv
// Velocity gradient stencil for one latitude row of a staggered lat-lon grid.
// Columns arrive on i_in, west halo first; a word with row_start set begins a
// new row. From the third column of a row each column yields one result word
// on o_out with the four gradient terms of the previous column.
// Geometry registers are written on the cfg port (index, data), ready always
// high; write them only while the block is idle.
// A column that gives no result leaves the block idle and ready. A column
// that gives a result occupies the block until all its arithmetic steps are
// done; the time is set by the shared bit-serial divider (one quotient bit
// per cycle, ten divisions per column) and the bit-serial multiplier.
// The result word sits in an output register; if the receiver stalls, the
// next column is still accepted and worked on, and its result waits until
// the register is free. i_in.ready is low while a column is being worked.
// Reset (i_rst_n low, synchronous) empties the output, clears the column
// count and restores the geometry registers to their defaults.
`default_nettype none

module sphere_velocity_gradient_stencil
    import sve_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sve_in_if.sink               i_in,
    sve_out_if.source            o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;
    logic  out_valid;

    assign o_cfg_ready = 1'b1;
    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

    sve_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sve_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_row_start    (i_in.row_start),
        .i_u_below      (i_in.u_below),
        .i_u_center     (i_in.u_center),
        .i_u_above      (i_in.u_above),
        .i_v_below      (i_in.v_below),
        .i_v_center     (i_in.v_center),
        .i_lon_step     (i_in.lon_step),
        .o_du_dlon      (o_out.du_dlon),
        .o_du_dlat_term (o_out.du_dlat_term),
        .o_dv_dlon      (o_out.dv_dlon),
        .o_dv_dlat_term (o_out.dv_dlat_term)
    );

endmodule

`default_nettype wire

### sim/sphere_velocity_gradient_stencil_tb.sv
// self-checking testbench of the sphere velocity gradient stencil
`default_nettype none

module sphere_velocity_gradient_stencil_tb;
    import sve_pkg::*;

    localparam int  FRAC       = FRAC_BITS_DEF;
    localparam int  BLOCK_LAT  = 1400;
    localparam longint CYCLE_LIMIT = 6000000;
    localparam logic signed [127:0] WMAX = {64'd0, MAX64};
    localparam logic signed [127:0] WMIN = {{64{1'b1}}, MIN64};

    typedef struct packed {
        logic        row_start;
        logic [63:0] u_below;
        logic [63:0] u_center;
        logic [63:0] u_above;
        logic [63:0] v_below;
        logic [63:0] v_center;
        logic [62:0] lon_step;
    } col_t;

    typedef struct packed {
        logic [63:0] du_dlon;
        logic [63:0] du_dlat_term;
        logic [63:0] dv_dlon;
        logic [63:0] dv_dlat_term;
    } grad_t;

    typedef struct packed {
        col_t  col;
        logic  typed;
        grad_t want;
    } row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    sve_in_if  in_ch();
    sve_out_if out_ch();

    sphere_velocity_gradient_stencil DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // geometry and column history as the block should hold them
    logic [62:0] g_radius, g_dlat_edge, g_dlat_below, g_dlat_above;
    logic [32:0] g_cos_lat;
    logic [63:0] g_tan_c, g_tan_eb, g_tan_ea;
    logic [63:0] u_hist [6];
    logic [63:0] v_hist [4];
    logic [62:0] lon_held;
    int          cols_seen;

    grad_t grad_q[$];
    int    fails = 0;
    int    send_idle = 0;
    int    recv_idle = 0;
    longint cycles = 0;
    logic  cur_typed = 1'b0;
    grad_t cur_want = '0;

    function automatic logic signed [127:0] wx(input logic [63:0] x);
        return {{64{x[63]}}, x};
    endfunction

    function automatic logic signed [127:0] sat64(input logic signed [127:0] a);
        if (a > WMAX) return WMAX;
        if (a < WMIN) return WMIN;
        return a;
    endfunction

    function automatic logic signed [127:0] qdiv(input logic signed [127:0] n,
                                                 input logic [127:0] d);
        logic [127:0] mag, q;
        if (d == 0) begin
            if (n == 0) return 0;
            return n[127] ? WMIN : WMAX;
        end
        mag = n[127] ? 128'(-n) : 128'(n);
        q = (mag << FRAC) / d;
        return sat64(n[127] ? -$signed(q) : $signed(q));
    endfunction

    function automatic logic signed [127:0] qmul(input logic signed [127:0] x,
                                                 input logic [63:0] y);
        logic [127:0] xm, ym, p;
        xm = x[127] ? 128'(-x) : 128'(x);
        ym = {64'd0, (y[63] ? -y : y)};
        p = (xm * ym) >> FRAC;
        return (x[127] ^ y[63]) ? -$signed(p) : $signed(p);
    endfunction

    function automatic logic signed [127:0] halve(input logic signed [127:0] x);
        logic [127:0] m;
        m = (x[127] ? 128'(-x) : 128'(x)) >> 1;
        return x[127] ? -$signed(m) : $signed(m);
    endfunction

    // gradient terms of the middle kept column, given the incoming column
    function automatic grad_t gradients(input col_t c);
        grad_t g;
        logic [127:0] rw, rc, lw;
        logic signed [127:0] t, dud, utan, dvd, vtan;
        rw = {65'd0, g_radius};
        rc = ({65'd0, g_radius} * {95'd0, g_cos_lat}) >> FRAC;
        lw = {65'd0, lon_held};
        t = qdiv(qdiv(wx(u_hist[4]) - wx(u_hist[1]), lw), rc);
        g.du_dlon = t[63:0];
        t = (wx(u_hist[2]) + wx(u_hist[5])) - (wx(u_hist[0]) + wx(u_hist[3]));
        dud = qdiv(qdiv(t, ({65'd0, g_dlat_below} + {65'd0, g_dlat_above}) << 1), rw);
        utan = qdiv(sat64(halve(qmul(wx(u_hist[1]) + wx(u_hist[4]), g_tan_c))), rw);
        t = sat64(dud + utan);
        g.du_dlat_term = t[63:0];
        t = (wx(c.v_below) + wx(c.v_center)) - (wx(v_hist[0]) + wx(v_hist[1]));
        t = qdiv(qdiv(t, lw << 2), rc);
        g.dv_dlon = t[63:0];
        dvd = qdiv(qdiv(wx(v_hist[3]) - wx(v_hist[2]), {65'd0, g_dlat_edge}), rw);
        vtan = qdiv(sat64(halve(qmul(wx(v_hist[2]), g_tan_eb)
                                + qmul(wx(v_hist[3]), g_tan_ea))), rw);
        t = sat64(dvd + vtan);
        g.dv_dlat_term = t[63:0];
        return g;
    endfunction

    task automatic clear_history();
        for (int k = 0; k < 6; k++) u_hist[k] = '0;
        for (int k = 0; k < 4; k++) v_hist[k] = '0;
        lon_held = '0;
        cols_seen = 0;
    endtask

    // prediction on every accepted word and register write
    always @(posedge i_clk) begin
        col_t c;
        grad_t g;
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            g_radius = '0; g_cos_lat = 33'h1_0000_0000; g_dlat_edge = '0;
            g_dlat_below = '0; g_dlat_above = '0;
            g_tan_c = '0; g_tan_eb = '0; g_tan_ea = '0;
            clear_history();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RADIUS:     g_radius = i_cfg_data[62:0];
                    CFG_COS_LAT:    g_cos_lat = i_cfg_data[32:0];
                    CFG_DLAT_EDGE:  g_dlat_edge = i_cfg_data[62:0];
                    CFG_DLAT_BELOW: g_dlat_below = i_cfg_data[62:0];
                    CFG_DLAT_ABOVE: g_dlat_above = i_cfg_data[62:0];
                    CFG_TAN_CENTER: g_tan_c = i_cfg_data;
                    CFG_TAN_EB:     g_tan_eb = i_cfg_data;
                    CFG_TAN_EA:     g_tan_ea = i_cfg_data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                c = '{in_ch.row_start, in_ch.u_below, in_ch.u_center, in_ch.u_above,
                      in_ch.v_below, in_ch.v_center, in_ch.lon_step};
                if (c.row_start) clear_history();
                if (cols_seen >= 2) begin
                    g = gradients(c);
                    grad_q.push_back(cur_typed ? cur_want : g);
                end
                u_hist[0] = u_hist[3]; u_hist[1] = u_hist[4]; u_hist[2] = u_hist[5];
                u_hist[3] = c.u_below; u_hist[4] = c.u_center; u_hist[5] = c.u_above;
                v_hist[0] = v_hist[2]; v_hist[1] = v_hist[3];
                v_hist[2] = c.v_below; v_hist[3] = c.v_center;
                lon_held = c.lon_step;
                if (cols_seen < 2) cols_seen++;
            end
        end
    end

    // result checking
    always @(posedge i_clk) begin
        grad_t w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (grad_q.size() == 0) begin
                $error("result word with nothing expected");
                fails++;
            end else begin
                w = grad_q.pop_front();
                if (out_ch.du_dlon !== w.du_dlon) begin
                    $error("du_dlon exp %h got %h", w.du_dlon, out_ch.du_dlon);
                    fails++;
                end
                if (out_ch.du_dlat_term !== w.du_dlat_term) begin
                    $error("du_dlat_term exp %h got %h", w.du_dlat_term, out_ch.du_dlat_term);
                    fails++;
                end
                if (out_ch.dv_dlon !== w.dv_dlon) begin
                    $error("dv_dlon exp %h got %h", w.dv_dlon, out_ch.dv_dlon);
                    fails++;
                end
                if (out_ch.dv_dlat_term !== w.dv_dlat_term) begin
                    $error("dv_dlat_term exp %h got %h", w.dv_dlat_term, out_ch.dv_dlat_term);
                    fails++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= (recv_idle == 0) ? 1'b1 : ($urandom_range(99) >= recv_idle);
    end

    initial begin
        in_ch.valid = 1'b0; in_ch.row_start = 1'b0;
        in_ch.u_below = '0; in_ch.u_center = '0; in_ch.u_above = '0;
        in_ch.v_below = '0; in_ch.v_center = '0; in_ch.lon_step = '0;
        out_ch.ready = 1'b1;
    end

    function automatic logic [63:0] pick64();
        case ($urandom_range(7))
            0: return MAX64;
            1: return MIN64;
            2: return '0;
            3: return 64'($signed($urandom_range(8000)) - 4000) << $urandom_range(40);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [62:0] pick_lon();
        case ($urandom_range(5))
            0: return '0;
            1: return {1'b0, 62'h3FFF_FFFF_FFFF_FFFF} | 63'h4000_0000_0000_0000;
            2: return 63'($urandom_range(1 << 20)) << 12;
            default: return 63'({$urandom, $urandom});
        endcase
    endfunction

    task automatic send_col(input col_t c, input logic typed, input grad_t want);
        if (send_idle != 0 && $urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle);
        end
        cur_typed = typed;
        cur_want  = want;
        in_ch.valid     <= 1'b1;
        in_ch.row_start <= c.row_start;
        in_ch.u_below   <= c.u_below;
        in_ch.u_center  <= c.u_center;
        in_ch.u_above   <= c.u_above;
        in_ch.v_below   <= c.v_below;
        in_ch.v_center  <= c.v_center;
        in_ch.lon_step  <= c.lon_step;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // drain the block before touching the geometry
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (grad_q.size() != 0) @(negedge i_clk);
        repeat (BLOCK_LAT) @(negedge i_clk);
    endtask

    task automatic set_geometry(input int kind);
        logic [63:0] v [8];
        for (int k = 0; k < 8; k++) v[k] = pick64();
        v[CFG_COS_LAT] = ($urandom_range(3) == 0) ? {$urandom, $urandom}
                                                 : 64'($urandom) + 64'($urandom_range(1));
        if (kind == 1) begin
            for (int k = 0; k < 8; k++) v[k] = '1;
        end else if (kind == 2) begin
            for (int k = 0; k < 8; k++) v[k] = '0;
        end else if (kind == 3) begin
            v[CFG_RADIUS] = 64'd6371 << FRAC;
            v[CFG_COS_LAT] = 64'h1_0000_0000;
            v[CFG_DLAT_EDGE] = 64'd1 << 26;
            v[CFG_DLAT_BELOW] = 64'd1 << 26;
            v[CFG_DLAT_ABOVE] = 64'd1 << 26;
            v[CFG_TAN_EB] = MIN64;
            v[CFG_TAN_EA] = MAX64;
        end
        settle();
        write_reg(CFG_RADIUS, v[CFG_RADIUS]);
        write_reg(CFG_COS_LAT, v[CFG_COS_LAT]);
        write_reg(CFG_DLAT_EDGE, v[CFG_DLAT_EDGE]);
        write_reg(CFG_DLAT_BELOW, v[CFG_DLAT_BELOW]);
        write_reg(CFG_DLAT_ABOVE, v[CFG_DLAT_ABOVE]);
        write_reg(CFG_TAN_CENTER, v[CFG_TAN_CENTER]);
        write_reg(CFG_TAN_EB, v[CFG_TAN_EB]);
        write_reg(CFG_TAN_EA, v[CFG_TAN_EA]);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic col_t rand_col(input logic start);
        col_t c;
        c.row_start = start;
        c.u_below = pick64(); c.u_center = pick64(); c.u_above = pick64();
        c.v_below = pick64(); c.v_center = pick64();
        c.lon_step = pick_lon();
        return c;
    endfunction

    row_t directed [$];

    initial begin
        int left, len, phase;
        col_t zc, mx, mn;
        grad_t zg;
        zc = '0;
        zg = '0;
        mx = '{1'b0, MAX64, MAX64, MAX64, MAX64, MAX64, 63'h7FFF_FFFF_FFFF_FFFF};
        mn = '{1'b0, MIN64, MIN64, MIN64, MIN64, MIN64, 63'd0};

        // defaults give zero divisors: zeros stay zero, others saturate
        directed.push_back('{zc, 1'b0, zg});  // no row start after reset
        directed.push_back('{zc, 1'b0, zg});
        directed.push_back('{zc, 1'b1, zg});
        directed.push_back('{mx, 1'b0, zg});
        directed.push_back('{mn, 1'b0, zg});
        directed.push_back('{mx, 1'b0, zg});
        zc.row_start = 1'b1;
        directed.push_back('{zc, 1'b0, zg});  // row start mid-row, no result
        mx.row_start = 1'b0;
        directed.push_back('{mn, 1'b0, zg});
        directed.push_back('{mx, 1'b0, zg});
        directed.push_back('{rand_col(1'b0), 1'b0, zg});

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[k]) send_col(directed[k].col, directed[k].typed, directed[k].want);

        // plausible geometry with a short directed row
        set_geometry(3);
        send_col(rand_col(1'b1), 1'b0, zg);
        for (int k = 0; k < 8; k++) send_col(rand_col(1'b0), 1'b0, zg);
        mn.row_start = 1'b0;
        send_col(mx, 1'b0, zg);
        send_col(mn, 1'b0, zg);
        send_col(mx, 1'b0, zg);

        for (phase = 0; phase < 6; phase++) begin
            set_geometry(phase == 1 ? 1 : phase == 4 ? 2 : phase == 2 ? 3 : 0);
            send_idle = (phase < 2) ? 24 : (phase < 4) ? 63 : 0;
            recv_idle = (phase < 2) ? 63 : (phase < 4) ? 24 : 0;
            left = 108;
            while (left > 0) begin
                if ($urandom_range(9) == 0) begin
                    // noise: loose columns without a row start
                    send_col(rand_col(1'b0), 1'b0, zg);
                    left--;
                end else begin
                    len = $urandom_range(3, 12);
                    send_col(rand_col(1'b1), 1'b0, zg);
                    for (int k = 1; k < len && left > 0; k++) begin
                        send_col(rand_col(1'b0), 1'b0, zg);
                        left--;
                    end
                    left--;
                end
            end
        end
        send_idle = 0;
        recv_idle = 0;
        settle();
        if (fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
